FILE: hw/rtl/qpt_pkg.sv
// Types and constants shared by the quaternion pose to transform pipeline.
package qpt_pkg;

  localparam int QW       = 16;      // working quaternion component width
  localparam int PW       = 32;      // product width
  localparam int SW       = 33;      // pair sum width
  localparam int NW       = 34;      // signed numerator width
  localparam int DW       = 33;      // divisor / magnitude width
  localparam int RW       = 34;      // partial remainder width
  localparam int TW       = 16;      // quotient width, holds up to 2^15
  localparam int RotW     = 16;
  localparam int TransW   = 32;
  localparam int NumRot   = 9;
  localparam int DivSteps = TW;

  localparam logic signed [RotW-1:0] OneQ14   = 16'sd16384;
  localparam logic [NumRot-1:0]      DiagMask = 9'b100010001;

  typedef struct packed {
    logic [2:0][TransW-1:0] trans;
    logic signed [PW-1:0]   xx;
    logic signed [PW-1:0]   yy;
    logic signed [PW-1:0]   zz;
    logic signed [PW-1:0]   ww;
    logic signed [PW-1:0]   xy;
    logic signed [PW-1:0]   xz;
    logic signed [PW-1:0]   yz;
    logic signed [PW-1:0]   xw;
    logic signed [PW-1:0]   yw;
    logic signed [PW-1:0]   zw;
  } prod_t;

  typedef struct packed {
    logic [2:0][TransW-1:0] trans;
    logic signed [SW-1:0]   xxww;
    logic signed [SW-1:0]   yyzz;
    logic signed [SW-1:0]   yyww;
    logic signed [SW-1:0]   xxzz;
    logic signed [SW-1:0]   zzww;
    logic signed [SW-1:0]   xxyy;
    logic signed [SW-1:0]   xy_m_zw;
    logic signed [SW-1:0]   xy_p_zw;
    logic signed [SW-1:0]   xz_p_yw;
    logic signed [SW-1:0]   xz_m_yw;
    logic signed [SW-1:0]   yz_m_xw;
    logic signed [SW-1:0]   yz_p_xw;
  } pair_t;

  typedef struct packed {
    logic [2:0][TransW-1:0]    trans;
    logic [DW-1:0]             n;
    logic [NumRot-1:0][NW-1:0] num;
  } num_t;

  typedef struct packed {
    logic [2:0][TransW-1:0]    trans;
    logic [DW-1:0]             den;
    logic                      zero;
    logic [NumRot-1:0]         neg;
    logic [NumRot-1:0][RW-1:0] rem;
    logic [NumRot-1:0][TW-1:0] quo;
  } div_t;

  typedef struct packed {
    logic [2:0][TransW-1:0]      trans;
    logic [NumRot-1:0][RotW-1:0] rot;
  } res_t;

endpackage

FILE: hw/rtl/qpt_prod.sv
// Input stage: component width adjust and the ten quaternion products.
module qpt_prod #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               vld_i,
  output logic                               rdy_o,
  input  logic [2:0][qpt_pkg::TransW-1:0]    trans_i,
  input  logic [3:0][QUAT_WIDTH-1:0]         quat_i,
  output logic                               vld_o,
  input  logic                               rdy_i,
  output qpt_pkg::prod_t                     prod_o
);
  import qpt_pkg::*;

  logic signed [QW-1:0] q16 [4];
  prod_t                prod_d;
  prod_t                prod_q;
  logic                 vld_q;

  for (genvar k = 0; k < 4; k++) begin : g_comp
    if (QUAT_WIDTH > QW) begin : g_narrow
      assign q16[k] = QW'($signed(quat_i[k]) >>> (QUAT_WIDTH - QW));
    end else begin : g_wide
      assign q16[k] = QW'($signed(quat_i[k]));
    end
  end

  // x = 0, y = 1, z = 2, w = 3
  always_comb begin
    prod_d.trans = trans_i;
    prod_d.xx    = PW'(q16[0]) * PW'(q16[0]);
    prod_d.yy    = PW'(q16[1]) * PW'(q16[1]);
    prod_d.zz    = PW'(q16[2]) * PW'(q16[2]);
    prod_d.ww    = PW'(q16[3]) * PW'(q16[3]);
    prod_d.xy    = PW'(q16[0]) * PW'(q16[1]);
    prod_d.xz    = PW'(q16[0]) * PW'(q16[2]);
    prod_d.yz    = PW'(q16[1]) * PW'(q16[2]);
    prod_d.xw    = PW'(q16[0]) * PW'(q16[3]);
    prod_d.yw    = PW'(q16[1]) * PW'(q16[3]);
    prod_d.zw    = PW'(q16[2]) * PW'(q16[3]);
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      prod_q <= prod_d;
    end
  end

  assign vld_o  = vld_q;
  assign prod_o = prod_q;

endmodule

FILE: hw/rtl/qpt_sum.sv
// Three stages: pair sums, numerators and norm, then magnitude and sign.
module qpt_sum (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  output logic            rdy_o,
  input  qpt_pkg::prod_t  prod_i,
  output logic            vld_o,
  input  logic            rdy_i,
  output qpt_pkg::div_t   div_o
);
  import qpt_pkg::*;

  pair_t s2_d, s2_q;
  num_t  s3_d, s3_q;
  div_t  s4_d, s4_q;
  logic  s2_vld_q, s3_vld_q, s4_vld_q;
  logic  s2_rdy, s3_rdy, s4_rdy;

  always_comb begin
    s2_d.trans   = prod_i.trans;
    s2_d.xxww    = SW'($signed(prod_i.xx)) + SW'($signed(prod_i.ww));
    s2_d.yyzz    = SW'($signed(prod_i.yy)) + SW'($signed(prod_i.zz));
    s2_d.yyww    = SW'($signed(prod_i.yy)) + SW'($signed(prod_i.ww));
    s2_d.xxzz    = SW'($signed(prod_i.xx)) + SW'($signed(prod_i.zz));
    s2_d.zzww    = SW'($signed(prod_i.zz)) + SW'($signed(prod_i.ww));
    s2_d.xxyy    = SW'($signed(prod_i.xx)) + SW'($signed(prod_i.yy));
    s2_d.xy_m_zw = SW'($signed(prod_i.xy)) - SW'($signed(prod_i.zw));
    s2_d.xy_p_zw = SW'($signed(prod_i.xy)) + SW'($signed(prod_i.zw));
    s2_d.xz_p_yw = SW'($signed(prod_i.xz)) + SW'($signed(prod_i.yw));
    s2_d.xz_m_yw = SW'($signed(prod_i.xz)) - SW'($signed(prod_i.yw));
    s2_d.yz_m_xw = SW'($signed(prod_i.yz)) - SW'($signed(prod_i.xw));
    s2_d.yz_p_xw = SW'($signed(prod_i.yz)) + SW'($signed(prod_i.xw));
  end

  // diagonal: n - 2(a + b) == sum of the other two squares minus these two
  always_comb begin
    logic signed [NW-1:0] n_w;
    n_w        = NW'($signed(s2_q.xxww)) + NW'($signed(s2_q.yyzz));
    s3_d.trans = s2_q.trans;
    s3_d.n     = n_w[DW-1:0];
    s3_d.num[0] = NW'($signed(s2_q.xxww)) - NW'($signed(s2_q.yyzz));
    s3_d.num[4] = NW'($signed(s2_q.yyww)) - NW'($signed(s2_q.xxzz));
    s3_d.num[8] = NW'($signed(s2_q.zzww)) - NW'($signed(s2_q.xxyy));
    s3_d.num[1] = {s2_q.xy_m_zw, 1'b0};
    s3_d.num[3] = {s2_q.xy_p_zw, 1'b0};
    s3_d.num[2] = {s2_q.xz_p_yw, 1'b0};
    s3_d.num[6] = {s2_q.xz_m_yw, 1'b0};
    s3_d.num[5] = {s2_q.yz_m_xw, 1'b0};
    s3_d.num[7] = {s2_q.yz_p_xw, 1'b0};
  end

  // |num| <= n always, so the magnitude fits the divisor width
  always_comb begin
    logic [NW-1:0] neg_v;
    logic [NW-1:0] mag_v;
    s4_d.trans = s3_q.trans;
    s4_d.den   = s3_q.n;
    s4_d.zero  = (s3_q.n == '0);
    for (int k = 0; k < NumRot; k++) begin
      neg_v        = NW'(0) - s3_q.num[k];
      s4_d.neg[k]  = s3_q.num[k][NW-1];
      mag_v        = s3_q.num[k][NW-1] ? neg_v : s3_q.num[k];
      s4_d.rem[k]  = RW'(mag_v[DW-1:0]);
      s4_d.quo[k]  = '0;
    end
  end

  assign s4_rdy = !s4_vld_q || rdy_i;
  assign s3_rdy = !s3_vld_q || s4_rdy;
  assign s2_rdy = !s2_vld_q || s3_rdy;
  assign rdy_o  = s2_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_vld_q <= vld_i;
      end
      if (s3_rdy) begin
        s3_vld_q <= s2_vld_q;
      end
      if (s4_rdy) begin
        s4_vld_q <= s3_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && vld_i) begin
      s2_q <= s2_d;
    end
    if (s3_rdy && s2_vld_q) begin
      s3_q <= s3_d;
    end
    if (s4_rdy && s3_vld_q) begin
      s4_q <= s4_d;
    end
  end

  assign vld_o = s4_vld_q;
  assign div_o = s4_q;

endmodule

FILE: hw/rtl/qpt_div_step.sv
// One restoring divide stage: one quotient bit for each of the nine entries.
module qpt_div_step (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  qpt_pkg::div_t  div_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output qpt_pkg::div_t  div_o
);
  import qpt_pkg::*;

  div_t             div_d;
  div_t             div_q;
  logic             vld_q;
  logic [NumRot-1:0] rem_ok;

  always_comb begin
    logic [RW-1:0] den_x;
    logic [RW-1:0] diff;
    logic [RW-1:0] rest;
    logic          ge;
    div_d = div_i;
    den_x = RW'(div_i.den);
    for (int k = 0; k < NumRot; k++) begin
      ge             = (div_i.rem[k] >= den_x);
      diff           = div_i.rem[k] - den_x;
      rest           = ge ? diff : div_i.rem[k];
      div_d.rem[k]   = {rest[RW-2:0], 1'b0};
      div_d.quo[k]   = {div_i.quo[k][TW-2:0], ge};
    end
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;

  always_comb begin
    for (int k = 0; k < NumRot; k++) begin
      rem_ok[k] = (div_q.rem[k] < {div_q.den, 1'b0});
    end
  end

  // partial remainder stays below twice the divisor for a nonzero norm
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && !div_q.zero) |-> (&rem_ok))
    else $error("partial remainder out of range");

endmodule

FILE: hw/rtl/qpt_round.sv
// Output stage: round to nearest, apply sign, identity for a zero norm.
module qpt_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  output logic           rdy_o,
  input  qpt_pkg::div_t  div_i,
  output logic           vld_o,
  input  logic           rdy_i,
  output qpt_pkg::res_t  res_o
);
  import qpt_pkg::*;

  res_t res_d;
  res_t res_q;
  logic vld_q;

  // quo holds floor(2 * ratio * 2^14); (quo + 1) / 2 rounds half away from zero
  always_comb begin
    logic [TW:0]     inc;
    logic [RotW-1:0] mag;
    res_d.trans = div_i.trans;
    for (int k = 0; k < NumRot; k++) begin
      inc = {1'b0, div_i.quo[k]} + (TW+1)'(1);
      mag = inc[TW:1];
      if (div_i.zero) begin
        res_d.rot[k] = DiagMask[k] ? OneQ14 : '0;
      end else if (div_i.neg[k]) begin
        res_d.rot[k] = RotW'(0) - mag;
      end else begin
        res_d.rot[k] = mag;
      end
    end
  end

  assign rdy_o = !vld_q || rdy_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy_o) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vld_i) begin
      res_q <= res_d;
    end
  end

  assign vld_o = vld_q;
  assign res_o = res_q;

endmodule

FILE: hw/rtl/quaternion_pose_to_transform.sv
// Pose to 3x4 rigid transform: pipelined quaternion to rotation matrix, translation passed on.
// One pose per cycle while out_stall_i is low; stages from input transaction to result transaction:
// one product stage, three add stages (pair sums, numerators and norm, magnitude),
// sixteen divide stages (one quotient bit per stage for all nine entries, each dividing
// by the squared norm), and one rounding stage. Every stage holds its transaction while
// stalled and fills bubbles, so while a result waits new input is still taken until all
// 21 stages are full. A zero quaternion yields the identity rotation.
module quaternion_pose_to_transform #(
  parameter int QUAT_WIDTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [31:0]           trans_x_i,
  input  logic [31:0]           trans_y_i,
  input  logic [31:0]           trans_z_i,
  input  logic [QUAT_WIDTH-1:0] quat_x_i,
  input  logic [QUAT_WIDTH-1:0] quat_y_i,
  input  logic [QUAT_WIDTH-1:0] quat_z_i,
  input  logic [QUAT_WIDTH-1:0] quat_w_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [15:0]           rot_00_o,
  output logic [15:0]           rot_01_o,
  output logic [15:0]           rot_02_o,
  output logic [31:0]           out_tx_o,
  output logic [15:0]           rot_10_o,
  output logic [15:0]           rot_11_o,
  output logic [15:0]           rot_12_o,
  output logic [31:0]           out_ty_o,
  output logic [15:0]           rot_20_o,
  output logic [15:0]           rot_21_o,
  output logic [15:0]           rot_22_o,
  output logic [31:0]           out_tz_o
);
  import qpt_pkg::*;

  prod_t             prod;
  logic              prod_vld, prod_rdy;
  logic              sum_rdy;
  div_t              div_w [DivSteps+1];
  logic [DivSteps:0] div_vld;
  logic [DivSteps:0] div_rdy;
  res_t              res;
  logic [NumRot-1:0] rot_ok;

  qpt_prod #(
    .QUAT_WIDTH (QUAT_WIDTH)
  ) u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_valid_i),
    .rdy_o   (prod_rdy),
    .trans_i ({trans_z_i, trans_y_i, trans_x_i}),
    .quat_i  ({quat_w_i, quat_z_i, quat_y_i, quat_x_i}),
    .vld_o   (prod_vld),
    .rdy_i   (sum_rdy),
    .prod_o  (prod)
  );

  assign in_stall_o = !prod_rdy;

  qpt_sum u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (prod_vld),
    .rdy_o  (sum_rdy),
    .prod_i (prod),
    .vld_o  (div_vld[0]),
    .rdy_i  (div_rdy[0]),
    .div_o  (div_w[0])
  );

  for (genvar s = 0; s < DivSteps; s++) begin : g_div
    qpt_div_step u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (div_vld[s]),
      .rdy_o  (div_rdy[s]),
      .div_i  (div_w[s]),
      .vld_o  (div_vld[s+1]),
      .rdy_i  (div_rdy[s+1]),
      .div_o  (div_w[s+1])
    );
  end

  qpt_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (div_vld[DivSteps]),
    .rdy_o  (div_rdy[DivSteps]),
    .div_i  (div_w[DivSteps]),
    .vld_o  (out_valid_o),
    .rdy_i  (!out_stall_i),
    .res_o  (res)
  );

  assign rot_00_o = res.rot[0];
  assign rot_01_o = res.rot[1];
  assign rot_02_o = res.rot[2];
  assign rot_10_o = res.rot[3];
  assign rot_11_o = res.rot[4];
  assign rot_12_o = res.rot[5];
  assign rot_20_o = res.rot[6];
  assign rot_21_o = res.rot[7];
  assign rot_22_o = res.rot[8];
  assign out_tx_o = res.trans[0];
  assign out_ty_o = res.trans[1];
  assign out_tz_o = res.trans[2];

  always_comb begin
    for (int k = 0; k < NumRot; k++) begin
      rot_ok[k] = ($signed(res.rot[k]) <= OneQ14) && ($signed(res.rot[k]) >= -OneQ14);
    end
  end

  // every rotation entry of a delivered transaction lies in [-1, 1]
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (&rot_ok))
    else $error("rotation entry out of range");

  // with the output side free, the whole pipeline advances and takes input
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is free");

  // input stalls only behind a held result transaction
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled with no held result");

endmodule

FILE: test/quaternion_pose_to_transform_tb.sv
// Testbench for quaternion_pose_to_transform: random and directed poses checked against a predictor.
`timescale 1ns / 100ps

module quaternion_pose_to_transform_tb;

  localparam int WATCHDOG    = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 30;
  localparam int NUM_RANDOM  = 650;
  localparam logic [15:0] ONE_Q14 = 16'sd16384;

  typedef struct packed {
    logic [31:0]        tx;
    logic [31:0]        ty;
    logic [31:0]        tz;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } pose_t;

  typedef struct packed {
    logic [8:0][15:0] rot;
    logic [2:0][31:0] trans;
  } transform_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] trans_x_i = '0;
  logic [31:0] trans_y_i = '0;
  logic [31:0] trans_z_i = '0;
  logic [15:0] quat_x_i = '0;
  logic [15:0] quat_y_i = '0;
  logic [15:0] quat_z_i = '0;
  logic [15:0] quat_w_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] rot_00_o, rot_01_o, rot_02_o;
  logic [15:0] rot_10_o, rot_11_o, rot_12_o;
  logic [15:0] rot_20_o, rot_21_o, rot_22_o;
  logic [31:0] out_tx_o, out_ty_o, out_tz_o;

  pose_t      poses_to_send[$];
  transform_t transforms_due[$];
  pose_t      cur_pose;
  logic       hold_rx = 1'b0;
  int         tx_idle_pct = 30;
  int         rx_idle_pct = 60;
  int         n_total = 0;
  int         n_sent = 0;
  int         n_checked = 0;
  int         n_errors = 0;
  int         n_zero = 0;
  int         n_blocked = 0;
  int         stuck = 0;

  quaternion_pose_to_transform u_top (.*);

  initial forever #2 clk_i = ~clk_i;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // rounds num * 2^14 / den to nearest, ties away from zero, then saturates
  function automatic logic [15:0] ratio_q14(longint num, longint den);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag * 32768 + den) / (2 * den);
    if (num < 0) q = -q;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return 16'(q);
  endfunction

  function automatic transform_t pose_to_transform(pose_t p);
    transform_t t;
    longint x, y, z, w, xx, yy, zz, ww, n;
    longint num [9];
    x = $signed(p.qx);
    y = $signed(p.qy);
    z = $signed(p.qz);
    w = $signed(p.qw);
    xx = x * x;
    yy = y * y;
    zz = z * z;
    ww = w * w;
    n = xx + yy + zz + ww;
    num[0] = n - 2 * (yy + zz);
    num[1] = 2 * (x * y - z * w);
    num[2] = 2 * (x * z + y * w);
    num[3] = 2 * (x * y + z * w);
    num[4] = n - 2 * (xx + zz);
    num[5] = 2 * (y * z - x * w);
    num[6] = 2 * (x * z - y * w);
    num[7] = 2 * (y * z + x * w);
    num[8] = n - 2 * (xx + yy);
    for (int k = 0; k < 9; k++) begin
      if (n == 0) t.rot[k] = (k % 4 == 0) ? ONE_Q14 : 16'd0;
      else t.rot[k] = ratio_q14(num[k], n);
    end
    t.trans[0] = p.tx;
    t.trans[1] = p.ty;
    t.trans[2] = p.tz;
    return t;
  endfunction

  task automatic add_pose(input logic [31:0] tx, ty, tz, input logic [15:0] qx, qy, qz, qw);
    pose_t p;
    p = '{tx: tx, ty: ty, tz: tz, qx: qx, qy: qy, qz: qz, qw: qw};
    if (qx == 0 && qy == 0 && qz == 0 && qw == 0) n_zero++;
    poses_to_send.insert(poses_to_send.size(), p);
  endtask

  function automatic logic [15:0] rand_component();
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 8)) - 16'd4;
      1: return 16'd0;
      2: return 16'($urandom_range(0, 1) ? 32'h8000 : 32'h7FFF);
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_trans();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want, got);
    n_errors++;
    if (n_errors <= 10)
      $display("mismatch in transform %0d, %s: expected %h, got %h",
               n_checked, field, want, got);
  endtask

  task automatic check_transform(input transform_t got);
    transform_t want;
    if (transforms_due.size() == 0) begin
      n_errors++;
      if (n_errors <= 10) $display("result transaction with no transform pending");
    end else begin
      want = transforms_due.pop_front();
      for (int k = 0; k < 9; k++)
        if (got.rot[k] !== want.rot[k])
          report_mismatch($sformatf("rot_%0d%0d", k / 3, k % 3), 32'(want.rot[k]),
                          32'(got.rot[k]));
      for (int k = 0; k < 3; k++)
        if (got.trans[k] !== want.trans[k])
          report_mismatch($sformatf("out_t%s", (k == 0) ? "x" : (k == 1) ? "y" : "z"),
                          want.trans[k], got.trans[k]);
      n_checked++;
    end
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        transforms_due.insert(transforms_due.size(), pose_to_transform(cur_pose));
        n_sent++;
      end else if (in_valid_i) begin
        n_blocked++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (poses_to_send.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          cur_pose = poses_to_send.pop_front();
          in_valid_i <= 1'b1;
          trans_x_i <= cur_pose.tx;
          trans_y_i <= cur_pose.ty;
          trans_z_i <= cur_pose.tz;
          quat_x_i <= cur_pose.qx;
          quat_y_i <= cur_pose.qy;
          quat_z_i <= cur_pose.qz;
          quat_w_i <= cur_pose.qw;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i)
        check_transform('{rot: {rot_22_o, rot_21_o, rot_20_o, rot_12_o, rot_11_o, rot_10_o,
                                rot_02_o, rot_01_o, rot_00_o},
                          trans: {out_tz_o, out_ty_o, out_tx_o}});
      out_stall_i <= hold_rx || ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))) stuck++;
    else stuck = 0;
    if (stuck >= WATCHDOG) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed poses
    add_pose(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    add_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    add_pose(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'sd0, 16'sd0, 16'sd0, -16'sd16384);
    add_pose(32'h0001_0000, 32'h0, 32'h0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'hFFFF_0000, 32'h0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0000_8000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    add_pose(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
             16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    add_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    add_pose(32'h5555_5555, 32'hAAAA_AAAA, 32'h0, -16'sd32768, 16'sd0, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd1, 16'sd0, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, 16'sd1);
    add_pose(32'h1, 32'h2, 32'h3, 16'sd1, 16'sd1, 16'sd1, 16'sd1);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd1, -16'sd1, 16'sd1, -16'sd1);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    add_pose(32'h0, 32'h0, 32'h0, -16'sd3, 16'sd5, -16'sd7, 16'sd2);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd1, 16'sd1, 16'sd0, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd1, 16'sd1, 16'sd1, 16'sd0);
    add_pose(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 16'sd0, -16'sd1);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 29) == 0)
        add_pose(rand_trans(), rand_trans(), rand_trans(), 16'd0, 16'd0, 16'd0, 16'd0);
      else
        add_pose(rand_trans(), rand_trans(), rand_trans(),
                 rand_component(), rand_component(), rand_component(), rand_component());
    end
    n_total = poses_to_send.size();

    wait (n_sent >= 230);
    tx_idle_pct <= 60;
    rx_idle_pct <= 30;
    wait (n_sent >= 460);
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    // long output hold-off while poses keep coming in
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_rx <= 1'b0;

    wait (n_sent == n_total);
    while (transforms_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d poses (%0d zero quaternions), %0d transforms checked", n_sent,
             n_zero, n_checked);
    $display("three idle phases plus a %0d cycle output hold-off, input blocked %0d cycles",
             HOLD_CYCLES, n_blocked);
    if (n_errors == 0 && transforms_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d transforms missing", n_errors, transforms_due.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
